// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 code point decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned REM_W  = 2;

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
  localparam logic [3:0]        LEAD4_HI   = 4'hF;
  localparam logic [2:0]        LEAD3_HI   = 3'h7;
  localparam logic [1:0]        LEAD2_HI   = 2'h3;
  localparam logic [REM_W-1:0]  REM_NONE   = 2'd0;
  localparam logic [REM_W-1:0]  REM_ONE    = 2'd1;
  localparam logic [REM_W-1:0]  REM_TWO    = 2'd2;
  localparam logic [REM_W-1:0]  REM_THREE  = 2'd3;

  typedef enum logic [2:0] {
    PH_LEAD = 3'b001,
    PH_SEQ  = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [REM_W-1:0]  rem;
    logic [CP_W-1:0]   acc;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            char_valid;
    logic            string_done;
    logic            error_flag;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== rtl/u8d_step.sv =====
// Decode step: next decoder state and result for one byte.
`timescale 1ns / 1ps
`default_nettype none

module u8d_step
  import u8d_pkg::*;
(
  input  dec_state_t        state,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              first_byte,
  input  logic              last_byte,
  output dec_state_t        state_next,
  output dec_result_t       result,
  output logic              result_valid
);

  dec_state_t       cur;
  logic [CP_W-1:0]  acc_shift;
  logic [REM_W-1:0] rem_dec;
  logic [5:0]       cont_bits;

  localparam dec_state_t STOP_STATE = '{phase: PH_STOP, rem: REM_NONE, acc: '0};
  localparam dec_state_t LEAD_STATE = '{phase: PH_LEAD, rem: REM_NONE, acc: '0};
  localparam dec_result_t ERR_RESULT =
    '{code_point: '0, char_valid: 1'b0, string_done: 1'b0, error_flag: 1'b1};

  always_comb begin
    cur       = first_byte ? LEAD_STATE : state;
    cont_bits = byte_value[5:0] & CONT_MASK[5:0];
    acc_shift = {cur.acc[CP_W-7:0], cont_bits};
    rem_dec   = cur.rem - REM_ONE;

    state_next   = cur;
    result       = '0;
    result_valid = 1'b0;

    case (cur.phase)
      PH_SEQ: begin
        if (rem_dec == REM_NONE) begin
          state_next          = last_byte ? STOP_STATE : LEAD_STATE;
          result.code_point   = acc_shift;
          result.char_valid   = 1'b1;
          result.string_done  = last_byte;
          result_valid        = 1'b1;
        end else if (last_byte) begin
          state_next   = STOP_STATE;
          result       = ERR_RESULT;
          result_valid = 1'b1;
        end else begin
          state_next.acc = acc_shift;
          state_next.rem = rem_dec;
        end
      end
      PH_LEAD: begin
        if (byte_value == '0) begin
          state_next         = STOP_STATE;
          result.string_done = 1'b1;
          result_valid       = 1'b1;
        end else if (!byte_value[7]) begin
          state_next         = last_byte ? STOP_STATE : LEAD_STATE;
          result.code_point  = {{(CP_W-BYTE_W){1'b0}}, byte_value};
          result.char_valid  = 1'b1;
          result.string_done = last_byte;
          result_valid       = 1'b1;
        end else if (byte_value[7:6] != LEAD2_HI || last_byte) begin
          state_next   = STOP_STATE;
          result       = ERR_RESULT;
          result_valid = 1'b1;
        end else begin
          state_next.phase = PH_SEQ;
          if (byte_value[7:4] == LEAD4_HI) begin
            state_next.rem = REM_THREE;
            state_next.acc = {{(CP_W-3){1'b0}}, byte_value[2:0]};
          end else if (byte_value[7:5] == LEAD3_HI) begin
            state_next.rem = REM_TWO;
            state_next.acc = {{(CP_W-4){1'b0}}, byte_value[3:0]};
          end else begin
            state_next.rem = REM_ONE;
            state_next.acc = {{(CP_W-5){1'b0}}, byte_value[4:0]};
          end
        end
      end
      default: begin
        state_next = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_to_code_point_decoder.sv =====
// Top level of the UTF-8 code point decoder: state, output stage, assertions.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a UTF-8 string per cycle and returns at most one result per
// byte, registered in the output stage. Throughput is one byte every cycle:
// the decode step is a single pass of logic from the state register to the
// output register, and a two-entry output stage (output register plus skid
// register) keeps taking bytes while the sink stalls until a second result
// is waiting; only then is the input stalled.
// first_byte clears the decoder before its byte is decoded; after a NUL lead,
// a completed character on last_byte, or an error, bytes give no result until
// the next first_byte.

module utf8_to_code_point_decoder
  import u8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              first_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CP_W-1:0]   code_point,
  output logic              char_valid,
  output logic              string_done,
  output logic              error_flag
);

  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t step_result;
  logic        step_valid;
  dec_result_t out_data;
  dec_result_t skid_data;
  logic        skid_valid;
  logic        in_take;
  logic        out_free;

  u8d_step u_step (
    .state        (state),
    .byte_value   (byte_value),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .state_next   (state_next),
    .result       (step_result),
    .result_valid (step_valid)
  );

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_LEAD;
      state.rem   <= REM_NONE;
      state.acc   <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= step_result;
        out_valid <= in_take && step_valid;
      end
    end else if (in_take && step_valid) begin
      skid_data  <= step_result;
      skid_valid <= 1'b1;
    end
  end

  assign code_point  = out_data.code_point;
  assign char_valid  = out_data.char_valid;
  assign string_done = out_data.string_done;
  assign error_flag  = out_data.error_flag;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a transaction while output is empty");

  a_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> !char_valid && !string_done && code_point == '0)
    else $error("error result carries other fields");

  a_cp_only_with_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> code_point == '0)
    else $error("code point set without a character");

  a_seq_has_rem: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_SEQ |-> state.rem != REM_NONE)
    else $error("inside a sequence with no bytes remaining");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

`default_nettype wire
